// ----- src/otps_pkg.sv -----
package otps_pkg;

  // Longest pattern held in the configuration registers
  localparam int unsigned MaxPattern = 8;
  // Width of a length, gap or byte count (holds 0..MaxPattern)
  localparam int unsigned CntW       = $clog2(MaxPattern + 1);
  localparam int unsigned PatW       = 8 * MaxPattern;
  localparam int unsigned AddrW      = 5;
  localparam int unsigned DataW      = 64;

  // Register indexes (paddr[4:3])
  localparam logic [1:0] RegFirstPattern  = 2'd0;
  localparam logic [1:0] RegFirstLength   = 2'd1;
  localparam logic [1:0] RegSecondPattern = 2'd2;
  localparam logic [1:0] RegSecondLength  = 2'd3;

  // Verdict bits
  localparam logic [1:0] VerdictNone     = 2'd0;
  localparam logic [1:0] VerdictForward  = 2'd1;
  localparam logic [1:0] VerdictBackward = 2'd2;

  typedef logic [MaxPattern-1:0][7:0] win_t;

  // Search phase: first stage, second stage, done
  typedef enum logic [2:0] {
    PhSeekFirst  = 3'b001,
    PhSeekSecond = 3'b010,
    PhFound      = 3'b100
  } phase_e;

  // Clamp a length register to 1..MaxPattern
  function automatic logic [CntW-1:0] eff_len(logic [3:0] reg_val);
    logic [CntW-1:0] n;
    n = CntW'(reg_val);
    if (reg_val == 4'd0) begin
      n = CntW'(1);
    end else if (32'(reg_val) > MaxPattern) begin
      n = CntW'(MaxPattern);
    end
    return n;
  endfunction

  // Count up, holding at MaxPattern
  function automatic logic [CntW-1:0] sat_inc(logic [CntW-1:0] v);
    return (32'(v) < MaxPattern) ? v + CntW'(1) : CntW'(MaxPattern);
  endfunction

  // Compare a pattern (plain or reversed) against the window ending at the newest byte
  function automatic logic win_match(win_t win, logic [PatW-1:0] pat,
                                     logic [CntW-1:0] len, logic [CntW-1:0] seen,
                                     logic rev);
    logic                          hit;
    logic [$clog2(MaxPattern)-1:0] k;
    hit = (seen >= len);
    for (int a = 0; a < MaxPattern; a++) begin
      k = rev ? $clog2(MaxPattern)'(a)
              : $clog2(MaxPattern)'(len - CntW'(1) - CntW'(a));
      if ((CntW'(a) < len) && (win[a] != pat[8*k +: 8])) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

endpackage

// ----- src/ordered_two_pattern_search.sv -----
// Channel  | Direction | Signals                          | Contents
// s_axis   | in        | tvalid tready tdata[7:0] tlast   | text_char, last_char on tlast
// m_axis   | out       | tvalid tready tdata[7:0]         | verdict in [1:0], zero above
// apb      | in        | psel penable pwrite paddr pwdata | four registers at 8*i
//
// One byte per cycle: a byte lands in the input register, the window compare and
// phase update run in the next cycle, and a verdict on the last byte goes to the
// output register. Throughput stalls only when a verdict waits in the output
// register and the next last byte is ready to advance. Reset (rst_ni low,
// asynchronous) clears search state, the patterns to zero and the lengths to one.
module ordered_two_pattern_search (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] text_char
  input  logic                           s_axis_tlast,
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,   // [1:0] verdict, [7:2] zero
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [otps_pkg::AddrW-1:0]     paddr,
  input  logic [otps_pkg::DataW-1:0]     pwdata,
  output logic [otps_pkg::DataW-1:0]     prdata,
  output logic                           pready
);

  // Configuration registers
  logic [otps_pkg::PatW-1:0] first_pat_q, second_pat_q;
  logic [3:0]                first_len_q, second_len_q;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_pat_q  <= '0;
      first_len_q  <= 4'd1;
      second_pat_q <= '0;
      second_len_q <= 4'd1;
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        otps_pkg::RegFirstPattern:  first_pat_q  <= pwdata;
        otps_pkg::RegFirstLength:   first_len_q  <= pwdata[3:0];
        otps_pkg::RegSecondPattern: second_pat_q <= pwdata;
        otps_pkg::RegSecondLength:  second_len_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[4:3])
      otps_pkg::RegFirstPattern:  prdata = first_pat_q;
      otps_pkg::RegFirstLength:   prdata = {60'd0, first_len_q};
      otps_pkg::RegSecondPattern: prdata = second_pat_q;
      otps_pkg::RegSecondLength:  prdata = {60'd0, second_len_q};
      default:                    prdata = '0;
    endcase
  end

  // Input register
  logic       in_valid_q, in_last_q;
  logic [7:0] in_char_q;
  logic       out_valid_q;
  logic [1:0] verdict_q;
  logic       out_free, adv;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign adv           = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // Search state
  otps_pkg::win_t             win_q, win_d;
  logic [otps_pkg::CntW-1:0]  seen_q, seen_d;
  logic [otps_pkg::CntW-1:0]  fwd_gap_q, fwd_gap_d, bwd_gap_q, bwd_gap_d;
  otps_pkg::phase_e           fwd_ph_q, fwd_ph_d, bwd_ph_q, bwd_ph_d;
  logic [otps_pkg::CntW-1:0]  l1, l2;
  logic [1:0]                 verdict_d;

  assign l1 = otps_pkg::eff_len(first_len_q);
  assign l2 = otps_pkg::eff_len(second_len_q);

  // Shift the byte in, then advance both searches
  always_comb begin
    win_d     = {win_q[otps_pkg::MaxPattern-2:0], in_char_q};
    seen_d    = otps_pkg::sat_inc(seen_q);
    fwd_ph_d  = fwd_ph_q;
    fwd_gap_d = fwd_gap_q;
    bwd_ph_d  = bwd_ph_q;
    bwd_gap_d = bwd_gap_q;

    unique case (fwd_ph_q)
      otps_pkg::PhSeekFirst: begin
        if (otps_pkg::win_match(win_d, first_pat_q, l1, seen_d, 1'b0)) begin
          fwd_ph_d  = otps_pkg::PhSeekSecond;
          fwd_gap_d = '0;
        end
      end
      otps_pkg::PhSeekSecond: begin
        fwd_gap_d = otps_pkg::sat_inc(fwd_gap_q);
        if (fwd_gap_d >= l2 &&
            otps_pkg::win_match(win_d, second_pat_q, l2, seen_d, 1'b0)) begin
          fwd_ph_d = otps_pkg::PhFound;
        end
      end
      default: ;
    endcase

    unique case (bwd_ph_q)
      otps_pkg::PhSeekFirst: begin
        if (otps_pkg::win_match(win_d, second_pat_q, l2, seen_d, 1'b1)) begin
          bwd_ph_d  = otps_pkg::PhSeekSecond;
          bwd_gap_d = '0;
        end
      end
      otps_pkg::PhSeekSecond: begin
        bwd_gap_d = otps_pkg::sat_inc(bwd_gap_q);
        if (bwd_gap_d >= l1 &&
            otps_pkg::win_match(win_d, first_pat_q, l1, seen_d, 1'b1)) begin
          bwd_ph_d = otps_pkg::PhFound;
        end
      end
      default: ;
    endcase

    verdict_d = otps_pkg::VerdictNone;
    if (fwd_ph_d == otps_pkg::PhFound) verdict_d = verdict_d | otps_pkg::VerdictForward;
    if (bwd_ph_d == otps_pkg::PhFound) verdict_d = verdict_d | otps_pkg::VerdictBackward;
  end

  // Commit the state; clear it after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= '0;
      seen_q    <= '0;
      fwd_ph_q  <= otps_pkg::PhSeekFirst;
      fwd_gap_q <= '0;
      bwd_ph_q  <= otps_pkg::PhSeekFirst;
      bwd_gap_q <= '0;
    end else if (adv) begin
      if (in_last_q) begin
        win_q     <= '0;
        seen_q    <= '0;
        fwd_ph_q  <= otps_pkg::PhSeekFirst;
        fwd_gap_q <= '0;
        bwd_ph_q  <= otps_pkg::PhSeekFirst;
        bwd_gap_q <= '0;
      end else begin
        win_q     <= win_d;
        seen_q    <= seen_d;
        fwd_ph_q  <= fwd_ph_d;
        fwd_gap_q <= fwd_gap_d;
        bwd_ph_q  <= bwd_ph_d;
        bwd_gap_q <= bwd_gap_d;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_last_q) begin
      verdict_q <= verdict_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, verdict_q};

  // A last byte leaves a verdict waiting and the search state cleared
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_last_q) |=> (out_valid_q && seen_q == '0 &&
                            fwd_ph_q == otps_pkg::PhSeekFirst &&
                            bwd_ph_q == otps_pkg::PhSeekFirst))
    else $error("state not cleared after last byte");

  // A last byte never advances over an unread verdict
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_last_q) |-> (!out_valid_q || m_axis_tready))
    else $error("verdict overwritten");

  // Counters stay within their saturation limit
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(seen_q) <= otps_pkg::MaxPattern) && (32'(fwd_gap_q) <= otps_pkg::MaxPattern) &&
    (32'(bwd_gap_q) <= otps_pkg::MaxPattern))
    else $error("counter beyond limit");

endmodule

// ----- tb/ordered_two_pattern_search_checker.sv -----
`timescale 1ns / 1ps

module ordered_two_pattern_search_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // text stream into the block
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] text_char
  input  logic                        s_axis_tlast,
  // verdict stream out of the block
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [7:0]                  m_axis_tdata,   // [1:0] verdict, [7:2] zero
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [otps_pkg::AddrW-1:0]  paddr,
  input  logic [otps_pkg::DataW-1:0]  pwdata,
  input  logic [otps_pkg::DataW-1:0]  prdata,
  input  logic                        pready,
  output int unsigned                 verdicts_pending_o,
  output int unsigned                 verdicts_checked_o,
  output int unsigned                 error_count_o
);

  // Shadow copy of the configuration registers
  logic [otps_pkg::PatW-1:0] first_pat;
  logic [otps_pkg::PatW-1:0] second_pat;
  logic [3:0]                first_len_reg;
  logic [3:0]                second_len_reg;

  // Search state of the predictor
  otps_pkg::win_t            window;
  int unsigned               bytes_seen;
  int unsigned               fwd_gap;
  int unsigned               bwd_gap;
  otps_pkg::phase_e          fwd_phase;
  otps_pkg::phase_e          bwd_phase;

  logic [1:0]                verdicts_due[$];

  // Map a length register onto 1..MaxPattern
  function automatic int unsigned clamp_length(logic [3:0] raw);
    if (raw == 4'd0) return 1;
    if (raw > otps_pkg::MaxPattern) return otps_pkg::MaxPattern;
    return raw;
  endfunction

  function automatic int unsigned count_up(int unsigned n);
    return (n < otps_pkg::MaxPattern) ? n + 1 : otps_pkg::MaxPattern;
  endfunction

  // True when the pattern (or its reverse) ends at the newest byte of the window
  function automatic logic window_holds(otps_pkg::win_t w, int unsigned seen,
                                        logic [otps_pkg::PatW-1:0] pat,
                                        int unsigned len, logic rev);
    int unsigned k;
    if (seen < len) return 1'b0;
    for (int unsigned a = 0; a < len; a++) begin
      k = rev ? a : len - 1 - a;
      if (w[a] != pat[8*k +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_search();
    window     = '0;
    bytes_seen = 0;
    fwd_gap    = 0;
    bwd_gap    = 0;
    fwd_phase  = otps_pkg::PhSeekFirst;
    bwd_phase  = otps_pkg::PhSeekFirst;
  endtask

  // Shift one text byte in, update both searches, queue a verdict on the last byte
  task automatic advance_search(input logic [7:0] ch, input logic last);
    int unsigned first_n;
    int unsigned second_n;
    logic [1:0]  verdict;
    first_n    = clamp_length(first_len_reg);
    second_n   = clamp_length(second_len_reg);
    window     = {window[otps_pkg::MaxPattern-2:0], ch};
    bytes_seen = count_up(bytes_seen);

    // forward: first pattern, then second pattern clear of it
    case (fwd_phase)
      otps_pkg::PhSeekFirst: begin
        if (window_holds(window, bytes_seen, first_pat, first_n, 1'b0)) begin
          fwd_phase = otps_pkg::PhSeekSecond;
          fwd_gap   = 0;
        end
      end
      otps_pkg::PhSeekSecond: begin
        fwd_gap = count_up(fwd_gap);
        if (fwd_gap >= second_n &&
            window_holds(window, bytes_seen, second_pat, second_n, 1'b0)) begin
          fwd_phase = otps_pkg::PhFound;
        end
      end
      default: ;
    endcase

    // backward: reversed second pattern, then reversed first pattern clear of it
    case (bwd_phase)
      otps_pkg::PhSeekFirst: begin
        if (window_holds(window, bytes_seen, second_pat, second_n, 1'b1)) begin
          bwd_phase = otps_pkg::PhSeekSecond;
          bwd_gap   = 0;
        end
      end
      otps_pkg::PhSeekSecond: begin
        bwd_gap = count_up(bwd_gap);
        if (bwd_gap >= first_n &&
            window_holds(window, bytes_seen, first_pat, first_n, 1'b1)) begin
          bwd_phase = otps_pkg::PhFound;
        end
      end
      default: ;
    endcase

    if (last) begin
      verdict = otps_pkg::VerdictNone;
      if (fwd_phase == otps_pkg::PhFound) verdict = verdict | otps_pkg::VerdictForward;
      if (bwd_phase == otps_pkg::PhFound) verdict = verdict | otps_pkg::VerdictBackward;
      verdicts_due.push_back(verdict);
      clear_search();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [1:0]                 want;
    logic [otps_pkg::DataW-1:0] reg_val;
    if (!rst_ni) begin
      first_pat      = '0;
      second_pat     = '0;
      first_len_reg  = 4'd1;
      second_len_reg = 4'd1;
      clear_search();
      verdicts_due.delete();
      verdicts_pending_o = 0;
    end else begin
      // compare the verdict transaction with the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        verdicts_checked_o++;
        if (verdicts_due.size() == 0) begin
          $error("verdict: none expected, got %0d", m_axis_tdata[1:0]);
          error_count_o++;
        end else begin
          want = verdicts_due.pop_front();
          if (m_axis_tdata[1:0] != want) begin
            $error("verdict: expected %0d, got %0d", want, m_axis_tdata[1:0]);
            error_count_o++;
          end
        end
        if (m_axis_tdata[7:2] != 6'd0) begin
          $error("tdata pad: expected 0, got %0h", m_axis_tdata[7:2]);
          error_count_o++;
        end
      end

      // step the predictor on each text transaction
      if (s_axis_tvalid && s_axis_tready) begin
        advance_search(s_axis_tdata, s_axis_tlast);
      end

      // track register writes, check register reads
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[4:3])
            otps_pkg::RegFirstPattern:  first_pat      = pwdata;
            otps_pkg::RegFirstLength:   first_len_reg  = pwdata[3:0];
            otps_pkg::RegSecondPattern: second_pat     = pwdata;
            otps_pkg::RegSecondLength:  second_len_reg = pwdata[3:0];
            default: ;
          endcase
        end else begin
          case (paddr[4:3])
            otps_pkg::RegFirstPattern:  reg_val = first_pat;
            otps_pkg::RegFirstLength:   reg_val = otps_pkg::DataW'(first_len_reg);
            otps_pkg::RegSecondPattern: reg_val = second_pat;
            default:                    reg_val = otps_pkg::DataW'(second_len_reg);
          endcase
          if (prdata != reg_val) begin
            $error("prdata at %0h: expected %0h, got %0h", paddr, reg_val, prdata);
            error_count_o++;
          end
        end
      end

      verdicts_pending_o = verdicts_due.size();
    end
  end

endmodule

// ----- tb/ordered_two_pattern_search_tb.sv -----
`timescale 1ns / 1ps

module ordered_two_pattern_search_tb;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [7:0]                 s_axis_tdata  = 8'd0;   // [7:0] text_char
  logic                       s_axis_tlast  = 1'b0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [7:0]                 m_axis_tdata;           // [1:0] verdict, [7:2] zero
  logic                       psel          = 1'b0;
  logic                       penable       = 1'b0;
  logic                       pwrite        = 1'b0;
  logic [otps_pkg::AddrW-1:0] paddr         = '0;
  logic [otps_pkg::DataW-1:0] pwdata        = '0;
  logic [otps_pkg::DataW-1:0] prdata;
  logic                       pready;

  int unsigned verdicts_pending;
  int unsigned verdicts_checked;
  int unsigned error_count;

  // Pacing of both sides, in percent of cycles
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Configuration as last programmed, used to shape the texts
  logic [otps_pkg::PatW-1:0] cfg_first_pat;
  logic [otps_pkg::PatW-1:0] cfg_second_pat;
  int unsigned               cfg_first_n;
  int unsigned               cfg_second_n;

  logic [7:0]  text_buf[$];
  int unsigned texts_sent;
  int unsigned bytes_sent;
  int unsigned settings_done;

  ordered_two_pattern_search uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  ordered_two_pattern_search_checker checker_i (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .s_axis_tvalid      (s_axis_tvalid),
    .s_axis_tready      (s_axis_tready),
    .s_axis_tdata       (s_axis_tdata),
    .s_axis_tlast       (s_axis_tlast),
    .m_axis_tvalid      (m_axis_tvalid),
    .m_axis_tready      (m_axis_tready),
    .m_axis_tdata       (m_axis_tdata),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .verdicts_pending_o (verdicts_pending),
    .verdicts_checked_o (verdicts_checked),
    .error_count_o      (error_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stall the verdict side at random
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // One APB transaction: setup cycle, then access until pready
  task automatic apb_access(input logic [1:0] idx, input logic wr,
                            input logic [otps_pkg::DataW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= otps_pkg::AddrW'({idx, 3'b000});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [otps_pkg::DataW-1:0] value);
    apb_access(idx, 1'b1, value);
    apb_access(idx, 1'b0, '0);
  endtask

  // Program all four registers; length writes carry random upper bits
  task automatic program_setting(input logic [otps_pkg::PatW-1:0] fp, input logic [3:0] fl,
                                 input logic [otps_pkg::PatW-1:0] sp, input logic [3:0] sl);
    logic [otps_pkg::DataW-1:0] junk;
    junk = {$urandom, $urandom};
    write_reg(otps_pkg::RegFirstPattern, fp);
    write_reg(otps_pkg::RegFirstLength, {junk[otps_pkg::DataW-1:4], fl});
    junk = {$urandom, $urandom};
    write_reg(otps_pkg::RegSecondPattern, sp);
    write_reg(otps_pkg::RegSecondLength, {junk[otps_pkg::DataW-1:4], sl});
    cfg_first_pat  = fp;
    cfg_second_pat = sp;
    cfg_first_n    = (fl == 4'd0) ? 1 :
                     (fl > otps_pkg::MaxPattern) ? otps_pkg::MaxPattern : fl;
    cfg_second_n   = (sl == 4'd0) ? 1 :
                     (sl > otps_pkg::MaxPattern) ? otps_pkg::MaxPattern : sl;
    settings_done++;
  endtask

  // Present one byte and hold it until the block takes it
  task automatic send_byte(input logic [7:0] ch, input logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_text();
    foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1);
    texts_sent++;
  endtask

  // Let every verdict come back, then give the pipeline time to empty
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (verdicts_pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Either a fully random byte or one taken from a pattern (near misses)
  function automatic logic [7:0] near_byte();
    if ($urandom_range(1) == 0) return 8'($urandom);
    if ($urandom_range(1) == 0) return cfg_first_pat[8*$urandom_range(7) +: 8];
    return cfg_second_pat[8*$urandom_range(7) +: 8];
  endfunction

  task automatic add_pattern(input logic [otps_pkg::PatW-1:0] pat, input int unsigned n,
                             input logic rev);
    for (int unsigned k = 0; k < n; k++) begin
      text_buf.push_back(rev ? pat[8*(n-1-k) +: 8] : pat[8*k +: 8]);
    end
  endtask

  // Mostly texts stitched from the patterns, their reverses and short fillers
  task automatic build_text();
    int unsigned parts;
    int unsigned n;
    text_buf.delete();
    if ($urandom_range(99) < 15) begin
      n = $urandom_range(12, 1);
      repeat (n) text_buf.push_back(8'($urandom));
    end else begin
      parts = ($urandom_range(19) == 0) ? $urandom_range(20, 8) : $urandom_range(6, 1);
      repeat (parts) begin
        case ($urandom_range(5))
          0: add_pattern(cfg_first_pat, cfg_first_n, 1'b0);
          1: add_pattern(cfg_second_pat, cfg_second_n, 1'b0);
          2: add_pattern(cfg_first_pat, cfg_first_n, 1'b1);
          3: add_pattern(cfg_second_pat, cfg_second_n, 1'b1);
          default: begin
            n = $urandom_range(3, 1);
            repeat (n) text_buf.push_back(near_byte());
          end
        endcase
      end
    end
  endtask

  initial begin
    logic [otps_pkg::PatW-1:0] fp;
    logic [otps_pkg::PatW-1:0] sp;
    logic [3:0]                fl;
    logic [3:0]                sl;
    int unsigned               mark;

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values of the registers
    apb_access(otps_pkg::RegFirstPattern, 1'b0, '0);
    apb_access(otps_pkg::RegFirstLength, 1'b0, '0);
    apb_access(otps_pkg::RegSecondPattern, 1'b0, '0);
    apb_access(otps_pkg::RegSecondLength, 1'b0, '0);

    // directed: both patterns are one zero byte after reset
    text_buf = '{8'h00};
    send_text();
    text_buf = '{8'h00, 8'h00};
    send_text();
    text_buf = '{8'hFF};
    send_text();
    drain();

    // directed: "ab" then "cd", forward, backward, both, and a text too short
    program_setting(64'h6261, 4'd2, 64'h6463, 4'd2);
    text_buf = '{8'h61, 8'h62, 8'h63, 8'h64};
    send_text();
    text_buf = '{8'h64, 8'h63, 8'h62, 8'h61};
    send_text();
    text_buf = '{8'h61, 8'h62, 8'h63, 8'h64, 8'h63, 8'h62, 8'h61};
    send_text();
    text_buf = '{8'h61};
    send_text();
    drain();

    // random phases, each with its own setting and pacing
    for (int unsigned s = 0; s < 12; s++) begin
      case (s)
        0: program_setting('1, 4'd8, '1, 4'd8);
        1: program_setting({$urandom, $urandom}, 4'd0, {$urandom, $urandom}, 4'd15);
        2: program_setting('0, 4'd1, '1, 4'd1);
        default: begin
          for (int unsigned k = 0; k < otps_pkg::MaxPattern; k++) begin
            fp[8*k +: 8] = ($urandom_range(1) == 0) ? 8'h61 : 8'h62;
          end
          case ($urandom_range(2))
            0: begin
              fp = {$urandom, $urandom};
              sp = {$urandom, $urandom};
            end
            1: begin
              for (int unsigned k = 0; k < otps_pkg::MaxPattern; k++) begin
                sp[8*k +: 8] = ($urandom_range(1) == 0) ? 8'h61 : 8'h62;
              end
            end
            default: sp = fp >> (8 * $urandom_range(3));
          endcase
          fl = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(8, 1));
          sl = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(8, 1));
          program_setting(fp, fl, sp, sl);
        end
      endcase

      case (s % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase

      mark = bytes_sent;
      while (bytes_sent - mark < 120) begin
        build_text();
        send_text();
      end
      drain();
    end

    $display("covered %0d texts, %0d text bytes, %0d verdicts checked",
             texts_sent, bytes_sent, verdicts_checked);
    $display("over %0d register settings and four pacing modes of both streams",
             settings_done);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
